// File: src/mbrpl_pkg.sv
`timescale 1ns / 1ps

package mbrpl_pkg;

  localparam logic [8:0] TableOffset = 9'h1BE;
  localparam logic [8:0] TableEnd    = 9'h1FE;
  localparam logic [8:0] SigLowPos   = 9'd510;
  localparam logic [8:0] LastPos     = 9'd511;
  localparam logic [7:0] SigLowByte  = 8'h55;
  localparam logic [7:0] SigHighByte = 8'hAA;
  localparam logic [7:0] FirstLogical = 8'd4;
  localparam logic [7:0] MaxLogical   = 8'd255;

  localparam logic [2:0] StReadNext    = 3'd0;
  localparam logic [2:0] StFound       = 3'd1;
  localparam logic [2:0] StNoSignature = 3'd2;
  localparam logic [2:0] StReadError   = 3'd3;
  localparam logic [2:0] StPrimAbsent  = 3'd4;
  localparam logic [2:0] StNoExtended  = 3'd5;
  localparam logic [2:0] StLogEmpty    = 3'd6;
  localparam logic [2:0] StLogNotFound = 3'd7;

  // Per-sector captures, plus the extended entry taken from the master record.
  typedef struct packed {
    logic [8:0]  pos;
    logic [7:0]  picked_type;
    logic [31:0] picked_start;
    logic [31:0] picked_length;
    logic        ext_seen;
    logic [31:0] ext_base;
    logic [7:0]  link_type;
    logic [31:0] link_start;
    logic        sig_low_ok;
  } cap_t;

  typedef struct packed {
    logic cap_en;
    logic clr_sector;
    logic restart;
  } ctl_t;

  function automatic logic is_extended(input logic [7:0] t);
    return (t == 8'h05) || (t == 8'h0F) || (t == 8'h85);
  endfunction

endpackage

// File: src/mbrpl_capture.sv
`timescale 1ns / 1ps

module mbrpl_capture
  import mbrpl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ctl_t       ctl,
  input  logic [7:0] sector_byte,
  input  logic       in_chain,
  input  logic [7:0] target,
  output cap_t       cap
);

  cap_t        cap_next;
  logic [8:0]  rel;
  logic [1:0]  entry;
  logic [3:0]  off;
  logic [31:0] lane_val;
  logic        in_table;
  logic        pick_sel;

  assign rel      = cap.pos - TableOffset;
  assign entry    = rel[5:4];
  assign off      = rel[3:0];
  assign lane_val = {24'd0, sector_byte} << {off[1:0], 3'b000};
  assign in_table = (cap.pos >= TableOffset) && (cap.pos < TableEnd);
  assign pick_sel = (!in_chain && (target < 8'd4) && (entry == target[1:0])) ||
                    (in_chain && (entry == 2'd0));

  always_comb begin
    cap_next = cap;
    if (ctl.restart) begin
      cap_next = '0;
    end else if (ctl.clr_sector) begin
      cap_next.pos           = '0;
      cap_next.picked_type   = '0;
      cap_next.picked_start  = '0;
      cap_next.picked_length = '0;
      cap_next.link_type     = '0;
      cap_next.link_start    = '0;
      cap_next.sig_low_ok    = 1'b0;
    end else if (ctl.cap_en) begin
      cap_next.pos = cap.pos + 9'd1;
      if (cap.pos == SigLowPos) begin
        cap_next.sig_low_ok = (sector_byte == SigLowByte);
      end
      if (in_table) begin
        if (pick_sel) begin
          if (off == 4'd4) begin
            cap_next.picked_type = sector_byte;
          end else if (off >= 4'd8 && off < 4'd12) begin
            cap_next.picked_start = cap.picked_start | lane_val;
          end else if (off >= 4'd12) begin
            cap_next.picked_length = cap.picked_length | lane_val;
          end
        end
        if (!in_chain) begin
          // In the master record the link type tracks the entry being passed.
          if (off == 4'd4) begin
            cap_next.link_type = sector_byte;
          end
          if (off >= 4'd8 && off < 4'd12 && !cap.ext_seen && is_extended(cap.link_type)) begin
            cap_next.ext_base = cap.ext_base | lane_val;
            if (off == 4'd11) begin
              cap_next.ext_seen = 1'b1;
            end
          end
        end else if (entry == 2'd1) begin
          if (off == 4'd4) begin
            cap_next.link_type = sector_byte;
          end else if (off >= 4'd8 && off < 4'd12) begin
            cap_next.link_start = cap.link_start | lane_val;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= '0;
    end else begin
      cap <= cap_next;
    end
  end

endmodule

// File: src/mbrpl_chain.sv
`timescale 1ns / 1ps

module mbrpl_chain
  import mbrpl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  sector_byte,
  input  logic        read_failed,
  input  logic [7:0]  target,
  input  cap_t        cap,
  input  logic        out_ready,
  output ctl_t        ctl,
  output logic        in_chain,
  output logic        out_valid,
  output logic [2:0]  status,
  output logic [31:0] next_sector,
  output logic [31:0] part_start_sector,
  output logic [31:0] part_length_sectors
);

  logic        in_chain_next;
  logic [31:0] chain_base;
  logic [31:0] chain_base_next;
  logic [31:0] table_sector;
  logic [31:0] table_sector_next;
  logic [7:0]  logical_number;
  logic [7:0]  logical_number_next;

  logic        last_byte;
  logic        sig_ok;
  logic        emit;
  logic        restart;
  logic [2:0]  res_status;
  logic [31:0] res_next;
  logic [31:0] res_start;
  logic [31:0] res_length;
  logic [31:0] logical_start;
  logic [31:0] link_sector;

  assign last_byte     = (cap.pos == LastPos);
  assign sig_ok        = cap.sig_low_ok && (sector_byte == SigHighByte);
  assign logical_start = table_sector + cap.picked_start;
  assign link_sector   = chain_base + cap.link_start;

  always_comb begin
    in_chain_next       = in_chain;
    chain_base_next     = chain_base;
    table_sector_next   = table_sector;
    logical_number_next = logical_number;
    emit       = 1'b0;
    restart    = 1'b0;
    res_status = StReadNext;
    res_next   = '0;
    res_start  = '0;
    res_length = '0;

    if (fire && read_failed) begin
      emit       = 1'b1;
      restart    = 1'b1;
      res_status = StReadError;
    end else if (fire && last_byte) begin
      emit = 1'b1;
      if (!in_chain) begin
        if (!sig_ok) begin
          restart    = 1'b1;
          res_status = StNoSignature;
        end else if (target < 8'd4) begin
          restart = 1'b1;
          if (cap.picked_type == 8'd0 || is_extended(cap.picked_type)) begin
            res_status = StPrimAbsent;
          end else begin
            res_status = StFound;
            res_start  = cap.picked_start;
            res_length = cap.picked_length;
          end
        end else if (!cap.ext_seen) begin
          restart    = 1'b1;
          res_status = StNoExtended;
        end else begin
          in_chain_next       = 1'b1;
          chain_base_next     = cap.ext_base;
          table_sector_next   = cap.ext_base;
          logical_number_next = FirstLogical;
          res_status          = StReadNext;
          res_next            = cap.ext_base;
        end
      end else begin
        if (!sig_ok) begin
          restart    = 1'b1;
          res_status = StLogNotFound;
        end else if (logical_number == target) begin
          restart = 1'b1;
          if (cap.picked_type == 8'd0) begin
            res_status = StLogEmpty;
          end else begin
            res_status = StFound;
            res_start  = logical_start;
            res_length = cap.picked_length;
          end
        end else if (!is_extended(cap.link_type) || logical_number == MaxLogical) begin
          restart    = 1'b1;
          res_status = StLogNotFound;
        end else begin
          table_sector_next   = link_sector;
          logical_number_next = logical_number + 8'd1;
          res_status          = StReadNext;
          res_next            = link_sector;
        end
      end
    end

    if (restart) begin
      in_chain_next       = 1'b0;
      chain_base_next     = '0;
      table_sector_next   = '0;
      logical_number_next = FirstLogical;
    end

    ctl.cap_en     = fire && !read_failed && !last_byte;
    ctl.clr_sector = emit;
    ctl.restart    = restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_chain       <= 1'b0;
      chain_base     <= '0;
      table_sector   <= '0;
      logical_number <= FirstLogical;
      out_valid      <= 1'b0;
    end else begin
      in_chain       <= in_chain_next;
      chain_base     <= chain_base_next;
      table_sector   <= table_sector_next;
      logical_number <= logical_number_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status              <= res_status;
      next_sector         <= res_next;
      part_start_sector   <= res_start;
      part_length_sectors <= res_length;
    end
  end

endmodule

// File: src/mbr_partition_locator_top.sv
`timescale 1ns / 1ps

// Walks an MBR partition table, and for logical targets the EBR chain, from a stream
// of sector bytes, one byte per transaction, starting with byte 0 of sector 0. After
// byte 511 of each sector (or at once on a byte flagged read_failed) one result
// transaction comes out: status 0 asks for the sector in next_sector to be streamed
// in next, status 1 gives the found partition, and any other status is a failure
// after which the next byte starts a fresh master record. The block takes one byte
// per cycle: a byte goes through an input register, the table capture and chain
// decision logic, and a result register. The input stalls only while a result waits
// to be taken. target_partition is written through target_partition_we; the user
// must write it only while no search is in flight, as the block does not enforce
// it; 0 to 3 select a primary entry, 4 and up a logical partition.

module mbr_partition_locator_top
  import mbrpl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        target_partition_we,
  input  logic [7:0]  target_partition,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  sector_byte,
  input  logic        read_failed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] next_sector,
  output logic [31:0] part_start_sector,
  output logic [31:0] part_length_sectors
);

  logic [7:0] target;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_failed;
  logic       advance;
  logic       fire;
  logic       in_chain;
  cap_t       cap;
  ctl_t       ctl;

  // The stage item moves on only when the result register can take a result.
  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      target   <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (target_partition_we) begin
        target <= target_partition;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte   <= sector_byte;
      s1_failed <= read_failed;
    end
  end

  mbrpl_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sector_byte (s1_byte),
    .in_chain    (in_chain),
    .target      (target),
    .cap         (cap)
  );

  mbrpl_chain u_chain (
    .clk                 (clk),
    .rst                 (rst),
    .fire                (fire),
    .sector_byte         (s1_byte),
    .read_failed         (s1_failed),
    .target              (target),
    .cap                 (cap),
    .out_ready           (out_ready),
    .ctl                 (ctl),
    .in_chain            (in_chain),
    .out_valid           (out_valid),
    .status              (status),
    .next_sector         (next_sector),
    .part_start_sector   (part_start_sector),
    .part_length_sectors (part_length_sectors)
  );

endmodule
